FILE: sv/tgb_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the toggle handshake byte bridge
// no dependencies

package tgb_pkg;

  localparam int TGB_QUEUE_DEPTH = 256;

  // item kinds
  localparam logic [1:0] KIND_POLL = 2'd0;
  localparam logic [1:0] KIND_MSG  = 2'd1;
  localparam logic [1:0] KIND_CMD  = 2'd2;

  // mode commands
  localparam logic [1:0] CMD_RECV = 2'd0;
  localparam logic [1:0] CMD_SYNC = 2'd1;
  localparam logic [1:0] CMD_IDLE = 2'd2;

  // run modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RECV = 2'd1;
  localparam logic [1:0] MODE_SYNC = 2'd2;
  localparam logic [1:0] MODE_SEND = 2'd3;

  // header characters
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_D = 8'h44;

  typedef struct packed {
    logic [1:0] kind;
    logic       peer_toggle;
    logic [7:0] pin_byte;
    logic [7:0] msg_byte0;
    logic [7:0] msg_byte1;
    logic [7:0] msg_byte2;
    logic       msg_complete;
    logic [1:0] mode_cmd;
  } tgb_item_t;

  typedef struct packed {
    logic       ready_level;
    logic [7:0] data_out;
    logic       drive_enable;
    logic       msg_out_valid;
    logic [7:0] msg_out0;
    logic [7:0] msg_out1;
    logic [7:0] msg_out2;
    logic [1:0] mode;
    logic       overflow;
  } tgb_result_t;

  // queue control for one step
  typedef struct packed {
    logic            clear;
    logic [1:0]      push_n;
    logic [2:0][7:0] push_data;
    logic [1:0]      pop_n;
  } tgb_qctl_t;

endpackage

FILE: sv/toggle_handshake_byte_bridge_core.sv
`timescale 1ns / 1ps
// top level of the toggle handshake byte bridge: input register, step logic,
// result register. depends on tgb_pkg, tgb_queue

// Takes one word (pin poll, incoming message or mode command) every clock
// and returns exactly one result word for it: the word waits in the input
// register and its result in the result register. Throughput is one word per
// cycle as long as results are taken; while a finished result waits, the
// input register still takes one more word. The queue holds QUEUE_DEPTH
// bytes in three byte-wide simple dual-port RAM banks, so a message can
// push its three bytes at once; the first two queued bytes live in
// flip-flops and the third is read ahead, which keeps the RAM read
// registered. The queue needs no clearing pass after reset: mode commands
// reset its pointers and only written entries are ever read.

module toggle_handshake_byte_bridge_core #(
  parameter int QUEUE_DEPTH = tgb_pkg::TGB_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  tgb_pkg::tgb_item_t   req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output tgb_pkg::tgb_result_t rsp
);

  import tgb_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  tgb_item_t   item_q;
  logic        item_vld;
  logic        advance;

  logic [1:0]    mode, mode_next;
  logic          own, own_next;
  logic [CW-1:0] count, count_next, c1, space, rel;
  logic [7:0]    w0, w0_next, w1, w1_next;
  logic          pin_drive, drive_next;
  logic [7:0]    pin_data, pdata_next;

  logic [7:0]      third;
  logic [7:0]      v0, v1, v2;
  logic [2:0][7:0] mb;
  logic [1:0]      n_msg;
  logic            hs, emit, dropped;
  logic [7:0]      m0, m1, m2;
  tgb_qctl_t       qctl;
  tgb_result_t     rsp_next;

  assign advance   = item_vld & (~rsp_valid | rsp_ready);
  assign req_ready = ~item_vld | advance;
  assign mb        = {item_q.msg_byte2, item_q.msg_byte1, item_q.msg_byte0};

  always_comb begin
    hs         = item_q.peer_toggle != own;
    mode_next  = mode;
    own_next   = own;
    count_next = count;
    w0_next    = w0;
    w1_next    = w1;
    drive_next = pin_drive;
    pdata_next = pin_data;
    emit       = 1'b0;
    dropped    = 1'b0;
    m0         = '0;
    m1         = '0;
    m2         = '0;
    qctl       = '0;
    v0         = w0;
    v1         = w1;
    v2         = third;
    c1         = count;
    space      = DEPTH_C - count;
    n_msg      = '0;
    rel        = '0;

    case (item_q.kind)
      KIND_POLL: begin
        case (mode)
          MODE_RECV: begin
            if (count != '0 && hs) begin
              pdata_next   = w0;
              w0_next      = w1;
              w1_next      = third;
              count_next   = count - 1'b1;
              own_next     = ~own;
              qctl.pop_n   = 2'd1;
            end
          end
          MODE_SEND: begin
            if (hs) begin
              own_next          = ~own;
              qctl.push_n       = 2'd1;
              qctl.push_data[0] = item_q.pin_byte;
              if (count == '0) begin
                w0_next    = item_q.pin_byte;
                count_next = CW'(1);
              end else if (count == CW'(1)) begin
                w1_next    = item_q.pin_byte;
                count_next = CW'(2);
              end else begin
                // third byte completes a message
                emit       = 1'b1;
                m0         = w0;
                m1         = w1;
                m2         = item_q.pin_byte;
                qctl.pop_n = 2'd3;
                count_next = '0;
              end
            end
          end
          MODE_SYNC: begin
            if (hs) begin
              own_next = ~own;
              if (item_q.pin_byte == CH_M || item_q.pin_byte == CH_I ||
                  item_q.pin_byte == CH_D) begin
                qctl.push_n       = 2'd1;
                qctl.push_data[0] = item_q.pin_byte;
                c1                = count + 1'b1;
                if (count == '0) begin
                  v0 = item_q.pin_byte;
                end else if (count == CW'(1)) begin
                  v1 = item_q.pin_byte;
                end else begin
                  v2 = item_q.pin_byte;
                end
              end
            end
            if (c1 == CW'(2) && v0 == CH_I) begin
              if (v1 == CH_D) begin
                mode_next = MODE_SEND;
              end
              qctl.pop_n = 2'd2;
              count_next = '0;
            end else if (c1 == CW'(3) && v0 == CH_M) begin
              if (v1 == CH_I && v2 == CH_D) begin
                mode_next = MODE_SEND;
              end
              qctl.pop_n = 2'd3;
              count_next = '0;
            end else if (c1 >= CW'(3)) begin
              // slide the header window by one word
              qctl.pop_n = 2'd1;
              count_next = c1 - 1'b1;
              w0_next    = v1;
              w1_next    = v2;
            end else begin
              count_next = c1;
              w0_next    = v0;
              w1_next    = v1;
            end
          end
          default: begin
          end
        endcase
      end
      KIND_MSG: begin
        if (item_q.msg_complete && mode == MODE_RECV) begin
          if (space >= CW'(3)) begin
            n_msg = 2'd3;
          end else begin
            n_msg   = space[1:0];
            dropped = 1'b1;
          end
          qctl.push_n    = n_msg;
          qctl.push_data = mb;
          count_next     = count + CW'(n_msg);
          for (int k = 0; k < 3; k++) begin
            rel = count + CW'(k);
            if (2'(k) < n_msg) begin
              if (rel == '0) begin
                w0_next = mb[k];
              end else if (rel == CW'(1)) begin
                w1_next = mb[k];
              end
            end
          end
        end
      end
      KIND_CMD: begin
        case (item_q.mode_cmd)
          CMD_RECV: begin
            qctl.clear     = 1'b1;
            qctl.push_n    = 2'd3;
            qctl.push_data = {CH_D, CH_I, CH_M};
            count_next     = CW'(3);
            w0_next        = CH_M;
            w1_next        = CH_I;
            drive_next     = 1'b1;
            pdata_next     = '0;
            mode_next      = MODE_RECV;
          end
          CMD_SYNC: begin
            qctl.clear = 1'b1;
            count_next = '0;
            drive_next = 1'b0;
            mode_next  = MODE_SYNC;
          end
          CMD_IDLE: begin
            qctl.clear = 1'b1;
            count_next = '0;
            drive_next = 1'b0;
            mode_next  = MODE_IDLE;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    rsp_next.ready_level   = own_next;
    rsp_next.data_out      = drive_next ? pdata_next : 8'd0;
    rsp_next.drive_enable  = drive_next;
    rsp_next.msg_out_valid = emit;
    rsp_next.msg_out0      = m0;
    rsp_next.msg_out1      = m1;
    rsp_next.msg_out2      = m2;
    rsp_next.mode          = mode_next;
    rsp_next.overflow      = dropped;
  end

  tgb_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .ctl   (qctl),
    .third (third)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld  <= 1'b0;
      rsp_valid <= 1'b0;
      mode      <= MODE_IDLE;
      own       <= 1'b0;
      count     <= '0;
      pin_drive <= 1'b0;
      pin_data  <= '0;
    end else begin
      if (req_ready) begin
        item_vld <= req_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
        mode      <= mode_next;
        own       <= own_next;
        count     <= count_next;
        pin_drive <= drive_next;
        pin_data  <= pdata_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item_q <= req;
    end
    if (advance) begin
      w0  <= w0_next;
      w1  <= w1_next;
      rsp <= rsp_next;
    end
  end

endmodule

FILE: sv/tgb_ram.sv
`timescale 1ns / 1ps
// one byte-wide queue bank: single write port, registered read port
// no dependencies

module tgb_ram #(
  parameter int ROWS = 2,
  localparam int AW = $clog2(ROWS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tgb_queue.sv
`timescale 1ns / 1ps
// byte queue storage: three interleaved banks, head/tail pointers and a
// look-ahead read of the third queued byte. depends on tgb_pkg, tgb_ram

module tgb_queue #(
  parameter int QUEUE_DEPTH = tgb_pkg::TGB_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  tgb_pkg::tgb_qctl_t  ctl,
  output logic [7:0]          third
);

  import tgb_pkg::*;

  localparam int BANKS = 3;
  localparam int ROWS  = (QUEUE_DEPTH + BANKS - 1) / BANKS;
  localparam int RW    = $clog2(ROWS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

  typedef struct packed {
    logic [RW-1:0] row;
    logic [1:0]    ph;
  } qptr_t;

  // advance a pointer by up to three words
  function automatic qptr_t adv(qptr_t p, logic [1:0] n);
    logic [2:0] s;
    qptr_t      r;
    s = {1'b0, p.ph} + {1'b0, n};
    r = p;
    if (s >= 3'd3) begin
      r.ph  = 2'(s - 3'd3);
      r.row = (p.row == ROW_LAST) ? '0 : p.row + 1'b1;
    end else begin
      r.ph = s[1:0];
    end
    return r;
  endfunction

  qptr_t head, tail;
  qptr_t head_next, tail_next, wbase, ra;
  qptr_t wa [BANKS];

  logic [1:0] n_push, n_pop;
  logic       do_clear;

  logic [BANKS-1:0] we_b;
  logic [RW-1:0]    waddr_b [BANKS];
  logic [7:0]       wdata_b [BANKS];
  logic [7:0]       rdata_b [BANKS];

  logic       byp_hit_next, byp_hit;
  logic [7:0] byp_data_next, byp_data;
  logic [1:0] rd_ph;

  assign do_clear = step & ctl.clear;
  assign n_push   = step ? ctl.push_n : 2'd0;
  assign n_pop    = step ? ctl.pop_n : 2'd0;

  always_comb begin
    head_next = do_clear ? '0 : adv(head, n_pop);
    wbase     = do_clear ? '0 : tail;
    tail_next = adv(wbase, n_push);
    ra        = adv(head_next, 2'd2);
    for (int k = 0; k < BANKS; k++) begin
      wa[k] = adv(wbase, 2'(k));
    end
  end

  // each pushed word lands in a different bank
  always_comb begin
    for (int p = 0; p < BANKS; p++) begin
      we_b[p]    = 1'b0;
      waddr_b[p] = '0;
      wdata_b[p] = '0;
      for (int k = 0; k < BANKS; k++) begin
        if (2'(k) < n_push && wa[k].ph == 2'(p)) begin
          we_b[p]    = 1'b1;
          waddr_b[p] = wa[k].row;
          wdata_b[p] = ctl.push_data[k];
        end
      end
    end
  end

  // a word written now at the look-ahead slot is not yet in the bank read
  always_comb begin
    byp_hit_next  = 1'b0;
    byp_data_next = '0;
    for (int k = 0; k < BANKS; k++) begin
      if (2'(k) < n_push && wa[k] == ra) begin
        byp_hit_next  = 1'b1;
        byp_data_next = ctl.push_data[k];
      end
    end
  end

  for (genvar p = 0; p < BANKS; p++) begin : g_bank
    tgb_ram #(.ROWS(ROWS)) u_ram (
      .clk   (clk),
      .we    (we_b[p]),
      .waddr (waddr_b[p]),
      .wdata (wdata_b[p]),
      .raddr (ra.row),
      .rdata (rdata_b[p])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      byp_hit <= 1'b0;
      rd_ph   <= '0;
    end else begin
      head    <= head_next;
      tail    <= tail_next;
      byp_hit <= byp_hit_next;
      rd_ph   <= ra.ph;
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= byp_data_next;
  end

  always_comb begin
    case (rd_ph)
      2'd0:    third = rdata_b[0];
      2'd1:    third = rdata_b[1];
      2'd2:    third = rdata_b[2];
      default: third = rdata_b[0];
    endcase
    if (byp_hit) begin
      third = byp_data;
    end
  end

endmodule
